/* hdl/typed_message_framer_ring_core_defines.svh */
// ----------------------------------------------------------------------------
// Typed message framer ring - assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef TYPED_MESSAGE_FRAMER_RING_CORE_DEFINES_SVH
`define TYPED_MESSAGE_FRAMER_RING_CORE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define TMFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true outside reset.
`define TMFR_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* hdl/tmfr_pkg.sv */
// ----------------------------------------------------------------------------
// Typed message framer ring - package
// Type codes, message lengths, operation codes and controller command type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmfr_pkg;

  // Type codes
  localparam logic [7:0] CODE_SYNC   = 8'h55;
  localparam logic [7:0] CODE_LONG   = 8'h65;
  localparam logic [7:0] CODE_SHORT  = 8'h61;
  localparam logic [7:0] CODE_CTL_A  = 8'h50;
  localparam logic [7:0] CODE_CTL_B  = 8'h52;
  localparam logic [7:0] CODE_CTL_C  = 8'h58;
  localparam logic [7:0] CODE_CTL_D  = 8'h80;
  localparam logic [7:0] CODE_STATUS = 8'h92;
  localparam logic [7:0] CODE_ACK    = 8'hEE;

  // Message lengths
  localparam logic [7:0] LEN_LONG    = 8'd67;
  localparam logic [7:0] LEN_SHORT   = 8'd4;
  localparam logic [7:0] LEN_CTL_OLD = 8'd16;
  localparam logic [7:0] LEN_CTL_NEW = 8'd20;
  localparam logic [7:0] LEN_STATUS  = 8'd10;
  localparam logic [7:0] LEN_ACK     = 8'd2;
  localparam logic [7:0] LEN_NONE    = 8'd0;

  localparam logic [7:0] SYNC_LEN_RESET = 8'd16;

  typedef enum logic [1:0] {
    MODE_RX      = 2'd0,
    MODE_READ    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_SYNC_LEN = 1'b0,
    CFG_NEW_FMT  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic load;   // capture the input transfer
    logic exec;   // framing, ring update, message byte read
    logic look;   // head descriptor read, read data capture
  } tmfr_cmd_t;

  // Length for a type code; sync length is passed in already clamped.
  function automatic logic [7:0] code_length(input logic [7:0] code,
                                             input logic [7:0] sync_len,
                                             input logic       new_fmt);
    logic [7:0] len;
    unique case (code)
      CODE_SYNC:   len = sync_len;
      CODE_LONG:   len = LEN_LONG;
      CODE_SHORT:  len = LEN_SHORT;
      CODE_CTL_A, CODE_CTL_B, CODE_CTL_C, CODE_CTL_D:
                   len = new_fmt ? LEN_CTL_NEW : LEN_CTL_OLD;
      CODE_STATUS: len = LEN_STATUS;
      CODE_ACK:    len = LEN_ACK;
      default:     len = LEN_NONE;
    endcase
    return len;
  endfunction

endpackage

/* hdl/tmfr_ctrl.sv */
// ----------------------------------------------------------------------------
// Typed message framer ring - controller
// Sequences one transfer through capture, execute, lookup and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "typed_message_framer_ring_core_defines.svh"

module tmfr_ctrl import tmfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tmfr_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_LOOK = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_LOOK;
      S_LOOK: state_d = S_OUT;
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec  = (state_q == S_EXEC);
  assign cmd_o.look  = (state_q == S_LOOK);

  `TMFR_ASSERT(a_load_exec, cmd_o.load |=> cmd_o.exec, "capture not followed by execute")
  `TMFR_ASSERT(a_exec_look, cmd_o.exec |=> cmd_o.look, "execute not followed by lookup")
  `TMFR_ASSERT(a_look_out, cmd_o.look |=> (out_valid_o && in_stall_o), "lookup not followed by result")

endmodule

/* hdl/tmfr_datapath.sv */
// ----------------------------------------------------------------------------
// Typed message framer ring - datapath
// Framing registers, ring pointers, message and descriptor memories, results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "typed_message_framer_ring_core_defines.svh"

module tmfr_datapath import tmfr_pkg::*; #(
  parameter int RING_DEPTH = 64,
  parameter int MSG_MAX    = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tmfr_cmd_t  cmd_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] rx_byte_i,
  input  logic [6:0] read_offset_i,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output logic [7:0] read_data_o,
  output logic [5:0] queue_count_o,
  output logic [7:0] head_type_o,
  output logic [7:0] head_length_o,
  output logic       message_stored_o,
  output logic       byte_dropped_o,
  output logic       overrun_o
);

  localparam int SW        = $clog2(RING_DEPTH);
  localparam int PW        = $clog2(MSG_MAX);
  localparam int AW        = SW + PW;
  localparam int MSG_DEPTH = RING_DEPTH * (2 ** PW);

  localparam logic [SW-1:0] LAST_SLOT = SW'(RING_DEPTH - 1);
  localparam logic [8:0]    MSG_MAX_L = 9'(MSG_MAX);

  // Configuration
  logic [7:0] sync_len_q;
  logic       new_fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_len_q <= SYNC_LEN_RESET;
      new_fmt_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_e'(cfg_index_i) == CFG_SYNC_LEN) sync_len_q <= cfg_data_i;
      else                                         new_fmt_q  <= cfg_data_i[0];
    end
  end

  logic [7:0] sync_eff;
  always_comb begin
    priority if (sync_len_q == 8'd0)                 sync_eff = 8'd1;
    else if ({1'b0, sync_len_q} > MSG_MAX_L)         sync_eff = MSG_MAX_L[7:0];
    else                                             sync_eff = sync_len_q;
  end

  // Captured transfer
  logic [1:0] mode_q;
  logic [7:0] rx_q;
  logic [6:0] off_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      rx_q   <= rx_byte_i;
      off_q  <= read_offset_i;
    end
  end

  // State
  logic [SW-1:0] wr_slot_q, rd_slot_q, count_q;
  logic [7:0]    cur_len_q, remain_q, type_q;
  logic          stored_q, dropped_q, over_q, rd_ok_q;
  logic [7:0]    msg_q, rdata_q;
  logic [15:0]   meta_q;

  logic [7:0]    code_len, eff_len, eff_rem, eff_type, pos, rem_next;
  logic          start, is_rx, is_read, is_rel, wr_en, done, full;
  logic          commit, over, dropped, release_ok, rd_ok;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [SW-1:0] wr_slot_nxt, rd_slot_nxt;

  always_comb begin
    is_rx    = (mode_e'(mode_q) == MODE_RX);
    is_read  = (mode_e'(mode_q) == MODE_READ);
    is_rel   = (mode_e'(mode_q) == MODE_RELEASE);
    code_len = code_length(rx_q, sync_eff, new_fmt_q);
    start    = (cur_len_q == 8'd0);
    eff_len  = start ? code_len : cur_len_q;
    eff_rem  = start ? code_len : remain_q;
    eff_type = start ? rx_q : type_q;
    pos      = eff_len - eff_rem;
    rem_next = eff_rem - 8'd1;
    done     = (rem_next == 8'd0);
    full     = (count_q == LAST_SLOT);
    wr_en    = cmd_i.exec && is_rx && (eff_len != 8'd0);
    commit   = wr_en && done && !full;
    over     = wr_en && done && full;
    dropped  = cmd_i.exec && is_rx && start && (code_len == 8'd0);
    release_ok = cmd_i.exec && is_rel && (count_q != '0);
    rd_ok    = is_read && (count_q != '0) && ({1'b0, off_q} < meta_q[7:0]);
    wr_addr  = {wr_slot_q, pos[PW-1:0]};
    rd_addr  = {rd_slot_q, PW'(off_q)};
    wr_slot_nxt = (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + SW'(1);
    rd_slot_nxt = (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + SW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q <= '0;
      rd_slot_q <= '0;
      count_q   <= '0;
      cur_len_q <= '0;
      remain_q  <= '0;
      stored_q  <= 1'b0;
      dropped_q <= 1'b0;
      over_q    <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        cur_len_q <= done ? 8'd0 : eff_len;
        remain_q  <= rem_next;
      end
      if (commit) begin
        wr_slot_q <= wr_slot_nxt;
        count_q   <= count_q + SW'(1);
      end
      if (release_ok) begin
        rd_slot_q <= rd_slot_nxt;
        count_q   <= count_q - SW'(1);
      end
      if (cmd_i.exec) begin
        stored_q  <= commit;
        dropped_q <= dropped;
        over_q    <= over;
        rd_ok_q   <= rd_ok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) type_q <= eff_type;
  end

  // Message bytes: slot-major, one row of 2**PW bytes per slot
  logic [7:0] msg_mem [MSG_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en) msg_mem[wr_addr] <= rx_q;
    if (cmd_i.exec) msg_q <= msg_mem[rd_addr];
  end

  // Slot descriptors: {type, length}, written at commit
  logic [15:0] meta_mem [RING_DEPTH];

  always_ff @(posedge clk_i) begin
    if (commit) meta_mem[wr_slot_q] <= {eff_type, eff_len};
    if (cmd_i.look) meta_q <= meta_mem[rd_slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) rdata_q <= rd_ok_q ? msg_q : 8'd0;
  end

  assign read_data_o      = rdata_q;
  assign queue_count_o    = 6'(count_q);
  assign head_type_o      = (count_q != '0) ? meta_q[15:8] : 8'd0;
  assign head_length_o    = (count_q != '0) ? meta_q[7:0]  : 8'd0;
  assign message_stored_o = stored_q;
  assign byte_dropped_o   = dropped_q;
  assign overrun_o        = over_q;

  `TMFR_ASSERT_NEVER(a_flag_excl, stored_q && over_q, "message both stored and discarded")
  `TMFR_ASSERT(a_frame_state, (cur_len_q != 8'd0) |-> (remain_q != 8'd0 && remain_q <= cur_len_q), "framing counters inconsistent")
  `TMFR_ASSERT(a_commit_count, commit |=> (count_q == $past(count_q) + SW'(1)), "commit did not bump count")

endmodule

/* hdl/typed_message_framer_ring_core.sv */
// ----------------------------------------------------------------------------
// Typed message framer ring - top level
// Frames received bytes into typed messages held in a ring of slots.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one operation per transfer:
// mode 0 frames rx_byte_i, mode 1 reads byte read_offset_i of the head
// message, mode 2 releases the head message, mode 3 only reports status.
// Output channel (out_valid_o / out_stall_i) returns one result per input
// transfer: read data, message count, head type and length, and the
// stored / dropped / overrun flags of that operation.
// One operation is in flight at a time. The result is valid once the input
// transfer has passed the execute state (registered read of the message
// memory) and the lookup state (registered read of the slot descriptor
// memory); a new input is taken the cycle after the output transfer.
// A stalled result holds; the input stays stalled until it is taken.
// Reset empties the ring and returns the framer to idle; the memories are
// not cleared. Sync length resets to 16, the control format to 16 bytes.
// Configuration writes take effect the next cycle; write only when idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module typed_message_framer_ring_core import tmfr_pkg::*; #(
  parameter int RING_DEPTH = 64,
  parameter int MSG_MAX    = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] rx_byte_i,
  input  logic [6:0] read_offset_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [5:0] queue_count_o,
  output logic [7:0] head_type_o,
  output logic [7:0] head_length_o,
  output logic       message_stored_o,
  output logic       byte_dropped_o,
  output logic       overrun_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  tmfr_cmd_t cmd;

  tmfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tmfr_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .MSG_MAX    (MSG_MAX)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .mode_i           (mode_i),
    .rx_byte_i        (rx_byte_i),
    .read_offset_i    (read_offset_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .read_data_o      (read_data_o),
    .queue_count_o    (queue_count_o),
    .head_type_o      (head_type_o),
    .head_length_o    (head_length_o),
    .message_stored_o (message_stored_o),
    .byte_dropped_o   (byte_dropped_o),
    .overrun_o        (overrun_o)
  );

endmodule

/* verif/typed_message_framer_ring_core_tb.sv */
// ----------------------------------------------------------------------------
// Typed message framer ring - testbench
// Drives framing, read and release operations through the valid/stall input
// channel and checks each result against a cycle-free ring model or typed row.
// It starts with a short table of directed operations, then fills the ring
// to overrun and runs random message traffic across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module typed_message_framer_ring_core_tb;
  import tmfr_pkg::*;

  localparam int RING_SLOTS   = 64;
  localparam int MSG_BYTES    = 128;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [7:0] rdata;
    logic [5:0] count;
    logic [7:0] htype;
    logic [7:0] hlen;
    logic       stored;
    logic       dropped;
    logic       overrun;
  } frame_res_t;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] rx;
    logic [6:0] off;
    logic       typed;   // res holds a hand-written expectation
    frame_res_t res;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  mode_e      mode_i;
  logic [7:0] rx_byte_i;
  logic [6:0] read_offset_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] read_data_o;
  logic [5:0] queue_count_o;
  logic [7:0] head_type_o;
  logic [7:0] head_length_o;
  logic       message_stored_o;
  logic       byte_dropped_o;
  logic       overrun_o;
  logic       cfg_we_i;
  cfg_idx_e   cfg_index_i;
  logic [7:0] cfg_data_i;

  typed_message_framer_ring_core #(
    .RING_DEPTH(RING_SLOTS),
    .MSG_MAX   (MSG_BYTES)
  ) i_dut (.*);

  // Model of the ring
  logic [7:0]  msg_mem [RING_SLOTS][MSG_BYTES];
  int unsigned msg_len [RING_SLOTS];
  int unsigned wr_slot, rd_slot, cur_len, remaining;
  logic [7:0]  sync_reg;
  logic        fmt_reg;

  frame_res_t  expected_results [$];
  int          mismatch_count;
  int          items_sent;
  int          cycle_count;
  bit          idling;
  int          stall_left, quiet_left;

  logic [7:0] msg_codes [9] = '{CODE_SYNC, CODE_LONG, CODE_SHORT, CODE_CTL_A, CODE_CTL_B,
                                CODE_CTL_C, CODE_CTL_D, CODE_STATUS, CODE_ACK};

  // Directed operations; typed rows carry an expectation read off by hand.
  stim_row_t directed_rows [20] = '{
    '{MODE_READ,    8'h00, 7'd0,   1'b1, '{8'h00, 6'd0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{MODE_RELEASE, 8'h00, 7'd0,   1'b1, '{8'h00, 6'd0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{MODE_NOP,     8'hFF, 7'd127, 1'b1, '{8'h00, 6'd0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{MODE_RX,      8'h00, 7'd0,   1'b1, '{8'h00, 6'd0, 8'h00, 8'd0, 1'b0, 1'b1, 1'b0}},
    '{MODE_RX,      8'hFF, 7'd127, 1'b1, '{8'h00, 6'd0, 8'h00, 8'd0, 1'b0, 1'b1, 1'b0}},
    '{MODE_RX,      8'hEE, 7'd0,   1'b1, '{8'h00, 6'd0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{MODE_RX,      8'hFF, 7'd0,   1'b1, '{8'h00, 6'd1, 8'hEE, 8'd2, 1'b1, 1'b0, 1'b0}},
    '{MODE_READ,    8'h00, 7'd1,   1'b1, '{8'hFF, 6'd1, 8'hEE, 8'd2, 1'b0, 1'b0, 1'b0}},
    '{MODE_READ,    8'hFF, 7'd0,   1'b1, '{8'hEE, 6'd1, 8'hEE, 8'd2, 1'b0, 1'b0, 1'b0}},
    '{MODE_READ,    8'h00, 7'd2,   1'b1, '{8'h00, 6'd1, 8'hEE, 8'd2, 1'b0, 1'b0, 1'b0}},
    '{MODE_READ,    8'h00, 7'd127, 1'b1, '{8'h00, 6'd1, 8'hEE, 8'd2, 1'b0, 1'b0, 1'b0}},
    '{MODE_RX,      8'h61, 7'd0,   1'b0, '0},
    '{MODE_RX,      8'h00, 7'd0,   1'b0, '0},
    '{MODE_RX,      8'hAA, 7'd0,   1'b0, '0},
    '{MODE_RX,      8'h55, 7'd0,   1'b0, '0},
    '{MODE_NOP,     8'h00, 7'd0,   1'b0, '0},
    '{MODE_RELEASE, 8'hFF, 7'd127, 1'b0, '0},
    '{MODE_READ,    8'h00, 7'd3,   1'b0, '0},
    '{MODE_RELEASE, 8'h00, 7'd0,   1'b0, '0},
    '{MODE_RELEASE, 8'h00, 7'd0,   1'b1, '{8'h00, 6'd0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}}
  };

  function automatic int unsigned ring_next(int unsigned s);
    return (s + 1 >= RING_SLOTS) ? 0 : s + 1;
  endfunction

  function automatic int unsigned ring_fill();
    return (wr_slot + RING_SLOTS - rd_slot) % RING_SLOTS;
  endfunction

  function automatic int unsigned msg_len_for(logic [7:0] code);
    int unsigned n;
    case (code)
      CODE_SYNC: begin
        n = 32'(sync_reg);
        if (n == 0) n = 1;
        if (n > MSG_BYTES) n = MSG_BYTES;
      end
      CODE_LONG:   n = 32'(LEN_LONG);
      CODE_SHORT:  n = 32'(LEN_SHORT);
      CODE_CTL_A, CODE_CTL_B, CODE_CTL_C, CODE_CTL_D:
                   n = fmt_reg ? 32'(LEN_CTL_NEW) : 32'(LEN_CTL_OLD);
      CODE_STATUS: n = 32'(LEN_STATUS);
      CODE_ACK:    n = 32'(LEN_ACK);
      default:     n = 0;
    endcase
    return n;
  endfunction

  // Advances the ring model by one operation and returns its status.
  function automatic frame_res_t frame_step(mode_e m, logic [7:0] rx, logic [6:0] off);
    frame_res_t  r;
    int unsigned n;
    r = '0;
    case (m)
      MODE_RX: begin
        if (cur_len == 0) begin
          n = msg_len_for(rx);
          if (n == 0) begin
            r.dropped = 1'b1;
          end else begin
            cur_len   = n;
            remaining = n;
          end
        end
        if (cur_len != 0) begin
          msg_mem[wr_slot][cur_len - remaining] = rx;
          remaining--;
          if (remaining == 0) begin
            // ring full: message is thrown away, slot stays free
            if (ring_next(wr_slot) == rd_slot) begin
              r.overrun = 1'b1;
            end else begin
              msg_len[wr_slot] = cur_len;
              wr_slot          = ring_next(wr_slot);
              r.stored         = 1'b1;
            end
            cur_len = 0;
          end
        end
      end
      MODE_READ: begin
        if (ring_fill() != 0 && off < msg_len[rd_slot]) r.rdata = msg_mem[rd_slot][off];
      end
      MODE_RELEASE: begin
        if (ring_fill() != 0) rd_slot = ring_next(rd_slot);
      end
      default: ;
    endcase
    r.count = 6'(ring_fill());
    if (r.count != 0) begin
      r.htype = msg_mem[rd_slot][0];
      r.hlen  = 8'(msg_len[rd_slot]);
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_op(mode_e m, logic [7:0] rx, logic [6:0] off,
                         input bit typed = 1'b0, input frame_res_t typed_res = '0);
    frame_res_t pred;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    rx_byte_i     <= rx;
    read_offset_i <= off;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = frame_step(m, rx, off);
    expected_results.push_back(typed ? typed_res : pred);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_read();
    logic [6:0] off;
    if (ring_fill() != 0 && $urandom_range(0, 3) != 0)
      off = 7'($urandom_range(0, msg_len[rd_slot] - 1));
    else
      off = 7'($urandom_range(0, 127));
    send_op(MODE_READ, 8'($urandom_range(0, 255)), off);
  endtask

  // Waits for the block to go idle, then writes one register.
  task automatic write_reg(cfg_idx_e idx, logic [7:0] data);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == CFG_SYNC_LEN) sync_reg = data;
    else fmt_reg = data[0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_traffic(int budget);
    int          start, pick, i;
    int unsigned code_len;
    logic [7:0]  code;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // well-formed message, now and then interleaved with reads/releases
        code = msg_codes[$urandom_range(0, 8)];
        if (code == CODE_SYNC && msg_len_for(CODE_SYNC) > 24 && $urandom_range(0, 3) != 0)
          code = CODE_ACK;
        code_len = msg_len_for(code);
        send_op(MODE_RX, code, 7'($urandom_range(0, 127)));
        for (i = 1; i < code_len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) != 0) send_read();
            else send_op(MODE_RELEASE, 8'($urandom_range(0, 255)),
                         7'($urandom_range(0, 127)));
          end
          send_op(MODE_RX, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        end
      end else if (pick < 68) begin
        repeat ($urandom_range(1, 4)) send_read();
      end else if (pick < 85) begin
        repeat (ring_fill() > 30 ? $urandom_range(1, 8) : $urandom_range(1, 3))
          send_op(MODE_RELEASE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
      end else begin
        // noise: stray bytes (which may open a frame) and arbitrary operations
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) != 0)
            send_op(MODE_RX, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
          else
            send_op(mode_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    7'($urandom_range(0, 127)));
        end
      end
    end
  endtask

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stalls in bursts, with quiet stretches between them.
  always @(negedge clk_i) begin
    if (!idling) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (quiet_left > 0) begin
      out_stall_i <= 1'b0;
      quiet_left--;
    end else begin
      out_stall_i <= 1'b0;
      case ($urandom_range(0, 7))
        0, 1:    stall_left = $urandom_range(1, 16);
        2:       quiet_left = $urandom_range(20, 100);
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    frame_res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{read_data_o, queue_count_o, head_type_o, head_length_o,
              message_stored_o, byte_dropped_o, overrun_o};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result transfer with nothing pending: rdata=%h count=%0d",
                   $realtime, got.rdata, got.count);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch exp rdata=%h count=%0d type=%h len=%0d st/dr/ov=%b%b%b",
                     $realtime, want.rdata, want.count, want.htype, want.hlen,
                     want.stored, want.dropped, want.overrun);
            $display("    got rdata=%h count=%0d type=%h len=%0d st/dr/ov=%b%b%b",
                     got.rdata, got.count, got.htype, got.hlen,
                     got.stored, got.dropped, got.overrun);
          end
        end
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_NOP;
    rx_byte_i     = '0;
    read_offset_i = '0;
    out_stall_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_SYNC_LEN;
    cfg_data_i    = '0;
    idling        = 1'b1;
    wr_slot       = 0;
    rd_slot       = 0;
    cur_len       = 0;
    remaining     = 0;
    sync_reg      = SYNC_LEN_RESET;
    fmt_reg       = 1'b0;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_op(directed_rows[i].mode, directed_rows[i].rx, directed_rows[i].off,
              directed_rows[i].typed, directed_rows[i].res);

    // Sync length 0 acts as 1: single-byte frames fill the ring quickly.
    write_reg(CFG_SYNC_LEN, 8'h00);
    write_reg(CFG_NEW_FMT, 8'h00);
    while (ring_fill() < RING_SLOTS - 1)
      send_op(MODE_RX, CODE_SYNC, 7'($urandom_range(0, 127)));
    send_op(MODE_RX, CODE_SYNC, 7'($urandom_range(0, 127)));
    send_op(MODE_RX, CODE_ACK, 7'($urandom_range(0, 127)));
    send_op(MODE_RX, 8'h5A, 7'($urandom_range(0, 127)));
    while (ring_fill() != 0) begin
      send_read();
      send_op(MODE_RELEASE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    end
    run_traffic(80);

    write_reg(CFG_SYNC_LEN, 8'hFF);
    write_reg(CFG_NEW_FMT, 8'h01);
    run_traffic(160);

    write_reg(CFG_SYNC_LEN, 8'h01);
    write_reg(CFG_NEW_FMT, 8'hFE);
    run_traffic(160);

    write_reg(CFG_SYNC_LEN, 8'd200);
    write_reg(CFG_NEW_FMT, 8'h03);
    run_traffic(120);

    write_reg(CFG_SYNC_LEN, 8'($urandom_range(2, 127)));
    write_reg(CFG_NEW_FMT, 8'($urandom_range(0, 255)));
    idling = 1'b0;
    run_traffic(240);
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
